FILE: rtl/ipd_pkg.sv
package ipd_pkg;

  // packet buffer depth, length byte included
  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = 9;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_OK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BAD_END = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_CHK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_LEN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic CFG_HEAD = 1'b0;
  localparam logic CFG_END  = 1'b1;

  localparam logic [7:0] HEAD_RST = 8'd70;
  localparam logic [7:0] END_RST  = 8'd22;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        offending_byte;
    logic [CNT_W-1:0]  stored_count;
    logic [7:0]        declared_length;
    logic [7:0]        running_sum;
  } result_t;

endpackage

FILE: rtl/ipd_if.sv
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink   (input valid, req_type, rx_byte, read_index, output ready);
  modport mon    (input valid, ready, req_type, rx_byte, read_index);
endinterface

interface ipd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipd_pkg::KIND_W-1:0]  result_kind;
  logic [7:0]                  offending_byte;
  logic [ipd_pkg::CNT_W-1:0]   stored_count;
  logic [7:0]                  declared_length;
  logic [7:0]                  running_sum;
  logic [7:0]                  expected_check;
  logic [7:0]                  read_data;

  modport source (output valid, result_kind, offending_byte, stored_count, declared_length,
                  running_sum, expected_check, read_data, input ready);
  modport sink   (input valid, result_kind, offending_byte, stored_count, declared_length,
                  running_sum, expected_check, read_data, output ready);
  modport mon    (input valid, ready, result_kind, offending_byte, stored_count,
                  declared_length, running_sum, expected_check, read_data);
endinterface

FILE: rtl/isp_packet_deframer.sv
// Packet deframer for a received byte stream with an 8-bit checksum.
// in_ch carries requests: req_type 0 hands in one received byte, req_type 1
// asks for packet buffer entry read_index. Frames are head byte, length L,
// L body bytes, end byte, checksum byte; the length byte and body land in a
// single-port-per-side buffer memory, entry 0 holding the length.
// out_ch carries at most one result per request: a packet verdict (ok, bad
// end byte, bad checksum, bad length) or the read data.
// cfg_we/cfg_index/cfg_data set the head and end marker bytes; write them
// only while the block is idle.
// Throughput: one request per cycle while in_ch.ready is high. A result
// passes through the registered memory read and s1 stage, then the output
// register. The stage between memory and output lets a request in while
// a result sits unclaimed; when both are full, in_ch.ready follows
// out_ch.ready.
// Reset (rst_n low, synchronous) drops any pending results, returns the
// parser to waiting for a head byte and restores the marker defaults. Buffer
// contents are not cleared; entries never written read back undefined.
module isp_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  ipd_in_if.sink                        in_ch,
  ipd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_END   = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0]                  phase_r, phase_nxt;
  logic [ipd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [7:0]                  len_r, len_nxt;
  logic [7:0]                  head_r, end_r;

  logic [7:0]                  mem [ipd_pkg::BUF_DEPTH];
  logic [7:0]                  mem_q_r;
  logic                        wr_en;
  logic [ipd_pkg::ADDR_W-1:0]  wr_addr;

  logic                        s1_v_r, s1_v_nxt;
  ipd_pkg::result_t            s1_r, s1_nxt;
  logic                        s1_rd_ok_r;
  logic                        out_v_r, out_v_nxt;
  ipd_pkg::result_t            out_r;
  logic [7:0]                  out_rd_r;

  logic                        in_acc, byte_acc, rd_acc, s1_adv, s1_load, emit;
  logic [7:0]                  b;
  logic                        hit;
  logic                        rd_ok;
  logic [ipd_pkg::CNT_W-1:0]   len_plus1, b_plus1, cnt_inc;
  logic [7:0]                  sum_b;
  ipd_pkg::result_t            em;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign byte_acc = in_acc && (in_ch.req_type == ipd_pkg::REQ_BYTE);
  assign rd_acc   = in_acc && (in_ch.req_type == ipd_pkg::REQ_READ);
  assign b        = in_ch.rx_byte;
  assign hit      = (b == head_r);
  assign sum_b    = sum_r + b;
  assign rd_ok    = {1'b0, in_ch.read_index} < ipd_pkg::DEPTH_C;
  assign len_plus1 = {1'b0, len_r} + 9'd1;
  assign b_plus1   = {1'b0, b} + 9'd1;
  assign cnt_inc   = (cnt_r < ipd_pkg::DEPTH_C) ? cnt_r + 9'd1 : cnt_r;

  // parser step for one received byte
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    emit      = 1'b0;
    em.kind            = ipd_pkg::KIND_OK;
    em.offending_byte  = b;
    em.stored_count    = cnt_r;
    em.declared_length = len_r;
    em.running_sum     = sum_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (hit) begin
          cnt_nxt   = '0;
          sum_nxt   = b;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        cnt_nxt = 9'd1;
        sum_nxt = sum_b;
        len_nxt = b;
        if (b == 8'd0 || b_plus1 > ipd_pkg::DEPTH_C) begin
          emit               = 1'b1;
          em.kind            = ipd_pkg::KIND_BAD_LEN;
          em.stored_count    = 9'd1;
          em.declared_length = b;
          em.running_sum     = sum_b;
          // recheck the same byte as a head
          if (hit) begin
            cnt_nxt   = '0;
            sum_nxt   = b;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (cnt_r < ipd_pkg::DEPTH_C) begin
          wr_en   = 1'b1;
          wr_addr = cnt_r[ipd_pkg::ADDR_W-1:0];
        end
        cnt_nxt = cnt_inc;
        sum_nxt = sum_b;
        if (len_plus1 <= cnt_inc) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (b == end_r) begin
          sum_nxt   = sum_b;
          phase_nxt = PH_CHECK;
        end else begin
          emit    = 1'b1;
          em.kind = ipd_pkg::KIND_BAD_END;
          if (hit) begin
            cnt_nxt   = '0;
            sum_nxt   = b;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_CHECK: begin
        emit = 1'b1;
        if (b == 8'(8'd0 - sum_r)) begin
          em.kind   = ipd_pkg::KIND_OK;
          phase_nxt = PH_IDLE;
        end else begin
          em.kind = ipd_pkg::KIND_BAD_CHK;
          if (hit) begin
            cnt_nxt   = '0;
            sum_nxt   = b;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign s1_load = rd_acc || (byte_acc && emit);

  always_comb begin
    if (rd_acc) begin
      s1_nxt      = '0;
      s1_nxt.kind = ipd_pkg::KIND_READ;
    end else begin
      s1_nxt = em;
    end
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      head_r  <= ipd_pkg::HEAD_RST;
      end_r   <= ipd_pkg::END_RST;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (byte_acc) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ipd_pkg::CFG_HEAD: head_r <= cfg_data;
          ipd_pkg::CFG_END:  end_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // packet buffer, registered read
  always_ff @(posedge clk) begin
    if (byte_acc && wr_en) begin
      mem[wr_addr] <= b;
    end
    if (rd_acc) begin
      mem_q_r <= mem[in_ch.read_index[ipd_pkg::ADDR_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      len_r <= len_nxt;
    end
    if (s1_load) begin
      s1_r       <= s1_nxt;
      s1_rd_ok_r <= rd_acc && rd_ok;
    end
    if (s1_adv) begin
      out_r    <= s1_r;
      out_rd_r <= (s1_r.kind == ipd_pkg::KIND_READ && s1_rd_ok_r) ? mem_q_r : 8'd0;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_kind     = out_r.kind;
  assign out_ch.offending_byte  = out_r.offending_byte;
  assign out_ch.stored_count    = out_r.stored_count;
  assign out_ch.declared_length = out_r.declared_length;
  assign out_ch.running_sum     = out_r.running_sum;
  assign out_ch.expected_check  = (out_r.kind == ipd_pkg::KIND_READ) ? 8'd0 :
                                  8'(8'd0 - out_r.running_sum);
  assign out_ch.read_data       = out_rd_r;

endmodule

FILE: rtl/ipd_checker.sv
module ipd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ipd_pkg::KIND_W-1:0] out_kind,
  input  logic [7:0]                 out_byte,
  input  logic [ipd_pkg::CNT_W-1:0]  out_count,
  input  logic [7:0]                 out_sum,
  input  logic [7:0]                 out_check,
  input  logic [7:0]                 out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // read results carry only read data
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ipd_pkg::KIND_READ |->
      out_byte == 8'd0 && out_count == '0 &&
      out_sum == 8'd0 && out_check == 8'd0)
    else $error("read result carries packet fields");

  // verdicts carry the negated sum and no read data
  a_verdict_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != ipd_pkg::KIND_READ |->
      8'(out_check + out_sum) == 8'd0 && out_data == 8'd0)
    else $error("verdict check byte inconsistent");

  // a clean packet ends on its expected checksum byte
  a_ok_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ipd_pkg::KIND_OK |->
      out_byte == out_check && out_count != '0)
    else $error("ok verdict without matching checksum");

endmodule

bind isp_packet_deframer ipd_checker u_ipd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_byte  (out_ch.offending_byte),
  .out_count (out_ch.stored_count),
  .out_sum   (out_ch.running_sum),
  .out_check (out_ch.expected_check),
  .out_data  (out_ch.read_data)
);
